@@ rtl/puf_pkg.sv @@
package puf_pkg;

    localparam logic [1:0] MODE_UNITE = 2'd0;
    localparam logic [1:0] MODE_SAME  = 2'd1;
    localparam logic [1:0] MODE_SIZE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] time_req;
        logic [9:0]  elem_a;
        logic [9:0]  elem_b;
    } t_in_item;

    typedef struct packed {
        logic        flag;
        logic [10:0] set_size;
    } t_out_item;

    typedef enum logic [2:0] {
        K_UNITE,
        K_SAME,
        K_SIZE,
        K_CLEAR,
        K_NULL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [19:0] time_req;
        logic [9:0]  elem_a;
        logic [9:0]  elem_b;
    } t_job;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WREQ,
        S_WCHK,
        S_HREQ,
        S_HDAT,
        S_LCHK,
        S_LREQ,
        S_LDAT,
        S_RXREQ,
        S_RXDAT,
        S_RYDAT,
        S_DONE
    } t_state;

endpackage

@@ rtl/puf_ram.sv @@
module puf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/puf_front.sv @@
module puf_front #(
    parameter int NODES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  puf_pkg::t_in_item i_in_item,
    output logic              o_job_valid,
    output puf_pkg::t_job     o_job,
    input  logic              i_job_pop
);
    puf_pkg::t_job r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp;
    logic          n_rp;
    logic [1:0]    n_cnt;
    logic          push;
    logic          a_ok;
    logic          b_ok;
    puf_pkg::t_job job_in;

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    assign a_ok = {22'd0, i_in_item.elem_a} < 32'(NODES);
    assign b_ok = {22'd0, i_in_item.elem_b} < 32'(NODES);

    always_comb begin
        job_in.time_req = i_in_item.time_req;
        job_in.elem_a   = i_in_item.elem_a;
        job_in.elem_b   = i_in_item.elem_b;
        case (i_in_item.mode)
            puf_pkg::MODE_UNITE: job_in.kind = (a_ok && b_ok) ? puf_pkg::K_UNITE
                                                               : puf_pkg::K_NULL;
            puf_pkg::MODE_SAME:  job_in.kind = (a_ok && b_ok) ? puf_pkg::K_SAME
                                                               : puf_pkg::K_NULL;
            puf_pkg::MODE_SIZE:  job_in.kind = a_ok ? puf_pkg::K_SIZE : puf_pkg::K_NULL;
            default:             job_in.kind = puf_pkg::K_CLEAR;
        endcase
    end

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = i_job_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_job_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ rtl/puf_back.sv @@
module puf_back #(
    parameter int NODES     = 1024,
    parameter int TIME_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  puf_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output puf_pkg::t_out_item o_out_item
);
    localparam int AW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 1);
    localparam int SW = $clog2(NODES + 1);
    localparam int TB = TIME_BITS;
    localparam int NW = 1 + TB + AW;
    localparam int RW = LW + SW;
    localparam int HW = TB + SW + LW;

    puf_pkg::t_state r_state, n_state;
    puf_pkg::t_job   r_job, n_job;
    logic [AW-1:0]   r_e, n_e;
    logic [AW-1:0]   r_x, n_x;
    logic [AW-1:0]   r_y, n_y;
    logic            r_which, n_which;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_reply, n_reply;
    logic [LW-1:0]   r_link, n_link;
    logic [LW-1:0]   r_count, n_count;
    logic [TB-1:0]   r_last, n_last;
    logic [SW-1:0]   r_xsize, n_xsize;
    logic [LW-1:0]   r_xhead, n_xhead;
    logic            r_flag, n_flag;
    logic [SW-1:0]   r_size, n_size;
    logic            r_out_valid, n_out_valid;
    puf_pkg::t_out_item r_out, n_out;

    logic [TB-1:0]   t_cur;
    logic [AW-1:0]   ea;
    logic [AW-1:0]   eb;
    logic [NW-1:0]   node_rdata, node_wdata;
    logic [RW-1:0]   root_rdata, root_wdata;
    logic [HW-1:0]   hist_rdata, hist_wdata;
    logic            node_we, root_we, hist_we;
    logic [AW-1:0]   node_waddr, root_waddr, root_raddr, hist_raddr;
    logic [LW-1:0]   link_m1;
    logic            nd_joined;
    logic [TB-1:0]   nd_time;
    logic [AW-1:0]   nd_par;
    logic [LW-1:0]   rt_head;
    logic [SW-1:0]   rt_size;
    logic [TB-1:0]   hs_time;
    logic [SW-1:0]   hs_size;
    logic [LW-1:0]   hs_prev;
    logic            swap;
    logic [AW-1:0]   big, small_r;
    logic [LW-1:0]   big_head;
    logic [SW-1:0]   sum;
    logic            unite_bad;

    assign t_cur = TB'(r_job.time_req);
    assign ea    = AW'(r_job.elem_a);
    assign eb    = AW'(r_job.elem_b);

    assign {nd_joined, nd_time, nd_par} = node_rdata;
    assign {rt_head, rt_size}           = root_rdata;
    assign {hs_time, hs_size, hs_prev}  = hist_rdata;

    assign link_m1    = r_link - LW'(1);
    assign hist_raddr = link_m1[AW-1:0];
    assign root_raddr = (r_state == puf_pkg::S_RXDAT) ? r_y : r_x;

    assign swap     = r_xsize < rt_size;
    assign big      = swap ? r_y : r_x;
    assign small_r  = swap ? r_x : r_y;
    assign big_head = swap ? rt_head : r_xhead;
    assign sum      = r_xsize + rt_size;

    assign unite_bad = (r_count >= LW'(NODES))
                    || ((r_count != '0) && (t_cur < r_last));

    puf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(r_e), .o_rdata(node_rdata)
    );
    puf_ram #(.WIDTH(RW), .DEPTH(NODES)) u_root (
        .i_clk(i_clk), .i_we(root_we), .i_waddr(root_waddr), .i_wdata(root_wdata),
        .i_raddr(root_raddr), .o_rdata(root_rdata)
    );
    puf_ram #(.WIDTH(HW), .DEPTH(NODES)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(r_count[AW-1:0]), .i_wdata(hist_wdata),
        .i_raddr(hist_raddr), .o_rdata(hist_rdata)
    );

    // Memory write controls.
    always_comb begin
        node_we    = 1'b0;
        root_we    = 1'b0;
        hist_we    = 1'b0;
        node_waddr = r_cnt;
        root_waddr = r_cnt;
        node_wdata = {1'b0, TB'(0), r_cnt};
        root_wdata = {LW'(0), SW'(1)};
        hist_wdata = {t_cur, sum, big_head};
        o_job_pop  = 1'b0;
        case (r_state)
            puf_pkg::S_CLEAR: begin
                node_we = 1'b1;
                root_we = 1'b1;
            end
            puf_pkg::S_IDLE: begin
                o_job_pop = i_job_valid && !r_out_valid;
            end
            puf_pkg::S_RYDAT: begin
                node_we    = 1'b1;
                root_we    = 1'b1;
                hist_we    = 1'b1;
                node_waddr = small_r;
                root_waddr = big;
                node_wdata = {1'b1, t_cur, big};
                root_wdata = {r_count + LW'(1), sum};
            end
            default: begin
            end
        endcase
    end

    // Next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_e         = r_e;
        n_x         = r_x;
        n_y         = r_y;
        n_which     = r_which;
        n_cnt       = r_cnt;
        n_reply     = r_reply;
        n_link      = r_link;
        n_count     = r_count;
        n_last      = r_last;
        n_xsize     = r_xsize;
        n_xhead     = r_xhead;
        n_flag      = r_flag;
        n_size      = r_size;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            puf_pkg::S_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(NODES - 1)) begin
                    n_cnt   = '0;
                    n_state = r_reply ? puf_pkg::S_DONE : puf_pkg::S_IDLE;
                end
            end
            puf_pkg::S_IDLE: begin
                if (i_job_valid && !r_out_valid) begin
                    n_job   = i_job;
                    n_state = puf_pkg::S_DISPATCH;
                end
            end
            puf_pkg::S_DISPATCH: begin
                n_flag  = 1'b0;
                n_size  = '0;
                n_e     = ea;
                n_which = 1'b0;
                case (r_job.kind)
                    puf_pkg::K_CLEAR: begin
                        n_cnt   = '0;
                        n_reply = 1'b1;
                        n_count = '0;
                        n_last  = '0;
                        n_state = puf_pkg::S_CLEAR;
                    end
                    puf_pkg::K_UNITE: begin
                        n_state = unite_bad ? puf_pkg::S_DONE : puf_pkg::S_WREQ;
                    end
                    puf_pkg::K_SAME, puf_pkg::K_SIZE: begin
                        n_state = puf_pkg::S_WREQ;
                    end
                    default: begin
                        n_state = puf_pkg::S_DONE;
                    end
                endcase
            end
            puf_pkg::S_WREQ: begin
                n_state = puf_pkg::S_WCHK;
            end
            puf_pkg::S_WCHK: begin
                if (nd_joined && (nd_time <= t_cur)) begin
                    n_e     = nd_par;
                    n_state = puf_pkg::S_WREQ;
                end else if (!r_which) begin
                    n_x = r_e;
                    if (r_job.kind == puf_pkg::K_SIZE) begin
                        n_state = puf_pkg::S_HREQ;
                    end else begin
                        n_e     = eb;
                        n_which = 1'b1;
                        n_state = puf_pkg::S_WREQ;
                    end
                end else begin
                    n_y = r_e;
                    if (r_job.kind == puf_pkg::K_SAME) begin
                        n_flag  = (r_x == r_e);
                        n_state = puf_pkg::S_DONE;
                    end else if (r_x == r_e) begin
                        n_state = puf_pkg::S_DONE;
                    end else begin
                        n_state = puf_pkg::S_RXREQ;
                    end
                end
            end
            puf_pkg::S_HREQ: begin
                n_state = puf_pkg::S_HDAT;
            end
            puf_pkg::S_HDAT: begin
                n_link  = rt_head;
                n_state = puf_pkg::S_LCHK;
            end
            puf_pkg::S_LCHK: begin
                if (r_link == '0) begin
                    n_size  = SW'(1);
                    n_state = puf_pkg::S_DONE;
                end else begin
                    n_state = puf_pkg::S_LREQ;
                end
            end
            puf_pkg::S_LREQ: begin
                n_state = puf_pkg::S_LDAT;
            end
            puf_pkg::S_LDAT: begin
                if (hs_time <= t_cur) begin
                    n_size  = hs_size;
                    n_state = puf_pkg::S_DONE;
                end else begin
                    n_link  = hs_prev;
                    n_state = puf_pkg::S_LCHK;
                end
            end
            puf_pkg::S_RXREQ: begin
                n_state = puf_pkg::S_RXDAT;
            end
            puf_pkg::S_RXDAT: begin
                n_xsize = rt_size;
                n_xhead = rt_head;
                n_state = puf_pkg::S_RYDAT;
            end
            puf_pkg::S_RYDAT: begin
                n_count = r_count + LW'(1);
                n_last  = t_cur;
                n_flag  = 1'b1;
                n_state = puf_pkg::S_DONE;
            end
            puf_pkg::S_DONE: begin
                n_out_valid       = 1'b1;
                n_out.flag        = r_flag;
                n_out.set_size    = 11'(r_size);
                n_reply           = 1'b0;
                n_state           = puf_pkg::S_IDLE;
            end
            default: begin
                n_state = puf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_e     <= n_e;
        r_x     <= n_x;
        r_y     <= n_y;
        r_which <= n_which;
        r_link  <= n_link;
        r_xsize <= n_xsize;
        r_xhead <= n_xhead;
        r_flag  <= n_flag;
        r_size  <= n_size;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= puf_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_reply     <= 1'b0;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_reply     <= n_reply;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

@@ rtl/persistent_union_find_unit.sv @@
// Partially persistent union-find engine with union by size.
// Input channel: i_in_valid / o_in_stall carry one item (mode, time_req,
// elem_a, elem_b); an item is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one result (flag, set_size)
// per item, in order.
// A two-entry queue accepts items while the engine works or a result waits.
// The engine runs one item at a time; every memory read goes through a
// registered RAM output. Each parent step of a root walk has a request and a
// check state, and each walk ends with one more such pair. A size query
// reads the root, then takes a check, request and data state per history
// entry, plus a check when the list runs out. A unite adds states to
// read both roots and write the merge, and every item has states to start,
// dispatch and return it. A walk has at most log2(NODES) steps; a size
// query may walk up to NODES - 1 history entries.
// After reset, and for a clear item, the engine sweeps all NODES entries of
// the node and root memories; items are queued but not started meanwhile.
// A clear item gives its zero result after the sweep.
// While the receiver stalls, the result holds and no new item is started.
module persistent_union_find_unit #(
    parameter int NODES     = 1024,
    parameter int TIME_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  puf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output puf_pkg::t_out_item o_out_item
);
    logic          job_valid;
    logic          job_pop;
    puf_pkg::t_job job;

    puf_front #(.NODES(NODES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    puf_back #(.NODES(NODES), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .o_job_pop(job_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid)
        else $error("Queue popped while empty.");

    a_pop_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !o_out_valid)
        else $error("Item started while a result still waits.");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_out_valid)
        else $error("Result valid right after reset.");
endmodule
